// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, switched off while rst_n is low
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked during reset
`define ESC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/esc_pkg.sv =====
package esc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
  localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
  localparam logic [2:0] REG_CAL_HUM_A   = 3'd4;
  localparam logic [2:0] REG_CAL_HUM_B   = 3'd5;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [32:0] T_FINE_OFS = 33'd128000;
  localparam logic [31:0] T_RND      = 32'd128;
  localparam logic [20:0] P_BASE     = 21'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [63:0] P_ONE47    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_FINE_OFS = 32'd76800;
  localparam logic [31:0] H_A_RND    = 32'd16384;
  localparam logic [31:0] H_C_OFS    = 32'd32768;
  localparam logic [31:0] H_D_OFS    = 32'd2097152;
  localparam logic [31:0] H_E_RND    = 32'd8192;
  localparam logic [31:0] HUM_MAX    = 32'd419430400;

  // request data that rides alongside the divider
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [16:0] hum;
    logic        neg;
    logic        dz;
  } side_t;

  function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

// ===== hdl/esc_div.sv =====
module esc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         in_num,
  input  logic [30:0]         in_den,
  input  esc_pkg::side_t      in_side,
  output logic                out_valid,
  output logic [63:0]         out_quo,
  output esc_pkg::side_t      out_side
);

  localparam int unsigned N = esc_pkg::DIV_STEPS;

  logic [N-1:0]   v_r;
  logic [30:0]    rem_r  [N];
  logic [63:0]    quo_r  [N];
  logic [30:0]    den_r  [N];
  esc_pkg::side_t side_r [N];

  logic [30:0]    rem_nxt [N];
  logic [63:0]    quo_nxt [N];

  // restoring division, numerator bits shift out of quo as quotient bits shift in
  always_comb begin
    logic [30:0] rsrc;
    logic [63:0] qsrc;
    logic [30:0] dsrc;
    logic [31:0] trial;
    logic        ge;
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        rsrc = '0;
        qsrc = in_num;
        dsrc = in_den;
      end else begin
        rsrc = rem_r[j-1];
        qsrc = quo_r[j-1];
        dsrc = den_r[j-1];
      end
      trial = {rsrc, qsrc[63]};
      ge    = trial >= {1'b0, dsrc};
      rem_nxt[j] = ge ? 31'(trial - {1'b0, dsrc}) : trial[30:0];
      quo_nxt[j] = {qsrc[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int j = 0; j < N; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
      end
      for (int j = 1; j < N; j++) begin
        den_r[j]  <= den_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hdl/env_sensor_compensation_top.sv =====
// 84 register stages, taking one request per cycle unless the output stalls.
// 14 front stages for temperature, humidity and the pressure numerator/divisor,
// a 64-stage divider (one quotient bit per stage), 6 back stages.
// The whole pipe advances together and holds while a finished result is not taken.
// Reset (synchronous, rst_n low) clears all valid bits and the calibration registers.
module env_sensor_compensation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_adc_temperature,
  input  logic [19:0] in_adc_pressure,
  input  logic [15:0] in_adc_humidity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_temperature_centi,
  output logic signed [31:0] out_fine_temperature,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_pressure_valid,
  output logic [16:0] out_humidity_q22_10,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  logic [47:0] cal_temp_r, cal_press_a_r, cal_press_b_r, cal_press_c_r;
  logic [31:0] cal_hum_a_r, cal_hum_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
      cal_hum_a_r   <= '0;
      cal_hum_b_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::REG_CAL_TEMP:    cal_temp_r    <= cfg_wdata;
        esc_pkg::REG_CAL_PRESS_A: cal_press_a_r <= cfg_wdata;
        esc_pkg::REG_CAL_PRESS_B: cal_press_b_r <= cfg_wdata;
        esc_pkg::REG_CAL_PRESS_C: cal_press_c_r <= cfg_wdata;
        esc_pkg::REG_CAL_HUM_A:   cal_hum_a_r   <= cfg_wdata[31:0];
        esc_pkg::REG_CAL_HUM_B:   cal_hum_b_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] t1, t2, t3;
  logic [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, cal_temp_r[15:0]};
  assign t2 = {{16{cal_temp_r[31]}}, cal_temp_r[31:16]};
  assign t3 = {{16{cal_temp_r[47]}}, cal_temp_r[47:32]};
  assign p1 = cal_press_a_r[15:0];
  assign p2 = cal_press_a_r[31:16];
  assign p3 = cal_press_a_r[47:32];
  assign p4 = cal_press_b_r[15:0];
  assign p5 = cal_press_b_r[31:16];
  assign p6 = cal_press_b_r[47:32];
  assign p7 = cal_press_c_r[15:0];
  assign p8 = cal_press_c_r[31:16];
  assign p9 = cal_press_c_r[47:32];
  assign h1 = {24'b0, cal_hum_a_r[7:0]};
  assign h2 = {{16{cal_hum_a_r[23]}}, cal_hum_a_r[23:8]};
  assign h3 = {24'b0, cal_hum_a_r[31:24]};
  assign h4 = {{20{cal_hum_b_r[11]}}, cal_hum_b_r[11:0]};
  assign h5 = {{20{cal_hum_b_r[23]}}, cal_hum_b_r[23:12]};
  assign h6 = {{24{cal_hum_b_r[31]}}, cal_hum_b_r[31:24]};

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [14:1] fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[13:1], in_valid};
    end
  end

  // carried fields
  logic [19:0] ap_r [1:7];
  logic [15:0] ah_r [1:5];
  logic [31:0] tc_r [4:13];
  logic [31:0] tf_r [4:13];
  logic [31:0] ha_r [6:10];
  logic [31:0] xm_r [11:13];
  logic [63:0] num_r [10:13];
  logic [30:0] den_r [10:13];

  logic [31:0] s1_m1_r, s1_m2_r, s2_v1_r, s2_m3_r, s3_tf_r;
  logic signed [32:0] s4_w1_r;
  logic [31:0] s4_hx_r;
  logic [63:0] s5_sq_r;
  logic signed [48:0] s5_a5_r, s5_a2_r, s6_a5_r, s6_a2_r, s7_a2_r;
  logic [31:0] s5_ma_r, s5_mb_r, s5_mc_r;
  logic signed [48:0] s6_p6l_r, s6_p3l_r;
  logic [31:0] s6_p6h_r, s6_p3h_r, s6_hb_r, s6_hc_r;
  logic [63:0] s7_w2_r, s7_t3v_r;
  logic [31:0] s7_md_r;
  logic [63:0] s8_y_r, s8_nd_r;
  logic [31:0] s8_d_r;
  logic [47:0] s9_yl_r;
  logic [31:0] s9_yh_r;
  logic [43:0] s9_nl_r;
  logic [31:0] s9_nh_r, s9_me_r, s10_e_r;
  logic [31:0] s12_mf_r, s13_mg_r;
  logic [63:0] s14_an_r;
  logic [30:0] s14_ad_r;
  esc_pkg::side_t s14_side_r;

  // stage wires
  logic [31:0] d1_w, d2_w, m3s_w, tf5_w;
  logic signed [65:0] sq_w;
  logic signed [48:0] a5_w, a2_w, p6l_w, p3l_w;
  logic [31:0] hc_w;
  logic [63:0] w2_w, t3v_w, t3s_w, y_w, nd_w, z_w, num_w;
  logic [20:0] pp_w;
  logic [31:0] mds_w, mes_w, xs_w, mfs_w, mgs_w, x_w, xc_w;
  logic [47:0] yl_w;
  logic [43:0] nl_w;
  logic [63:0] an_w;
  logic [30:0] ad_w;
  logic        nn_w, dn_w;

  assign d1_w  = {15'b0, in_adc_temperature[19:3]} - {t1[30:0], 1'b0};
  assign d2_w  = {16'b0, in_adc_temperature[19:4]} - t1;
  assign m3s_w = $signed(s2_m3_r) >>> 14;
  assign tf5_w = s3_tf_r + {s3_tf_r[29:0], 2'b0};
  assign sq_w  = s4_w1_r * s4_w1_r;
  assign a5_w  = s4_w1_r * p5;
  assign a2_w  = s4_w1_r * p2;
  assign p6l_w = $signed({1'b0, s5_sq_r[31:0]}) * p6;
  assign p3l_w = $signed({1'b0, s5_sq_r[31:0]}) * p3;
  assign hc_w  = $signed(s5_mc_r) >>> 11;
  assign w2_w  = {{15{s6_p6l_r[48]}}, s6_p6l_r} + {s6_p6h_r, 32'b0}
               + ({{15{s6_a5_r[48]}}, s6_a5_r} << 17) + ({{48{p4[15]}}, p4} << 35);
  assign t3v_w = {{15{s6_p3l_r[48]}}, s6_p3l_r} + {s6_p3h_r, 32'b0};
  assign t3s_w = $signed(s7_t3v_r) >>> 8;
  assign y_w   = esc_pkg::P_ONE47 + t3s_w + ({{15{s7_a2_r[48]}}, s7_a2_r} << 12);
  assign pp_w  = esc_pkg::P_BASE - {1'b0, ap_r[7]};
  assign nd_w  = {12'b0, pp_w, 31'b0} - s7_w2_r;
  assign mds_w = $signed(s7_md_r) >>> 10;
  assign yl_w  = 48'(s8_y_r[31:0]) * 48'(p1);
  assign nl_w  = 44'(s8_nd_r[31:0]) * 44'(esc_pkg::P_SCALE);
  assign z_w   = {16'b0, s9_yl_r} + {s9_yh_r, 32'b0};
  assign num_w = {20'b0, s9_nl_r} + {s9_nh_r, 32'b0};
  assign mes_w = $signed(s9_me_r + esc_pkg::H_E_RND) >>> 14;
  assign xs_w  = $signed(xm_r[11]) >>> 15;
  assign mfs_w = $signed(s12_mf_r) >>> 7;
  assign mgs_w = $signed(s13_mg_r) >>> 4;
  assign x_w   = xm_r[13] - mgs_w;
  assign xc_w  = x_w[31] ? 32'd0 : ((x_w > esc_pkg::HUM_MAX) ? esc_pkg::HUM_MAX : x_w);
  assign nn_w  = num_r[13][63];
  assign dn_w  = den_r[13][30];
  assign an_w  = nn_w ? (64'd0 - num_r[13]) : num_r[13];
  assign ad_w  = dn_w ? (31'd0 - den_r[13]) : den_r[13];

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      ap_r[1] <= in_adc_pressure;
      ah_r[1] <= in_adc_humidity;
      for (int k = 2; k <= 7; k++) ap_r[k] <= ap_r[k-1];
      for (int k = 2; k <= 5; k++) ah_r[k] <= ah_r[k-1];
      s1_m1_r <= esc_pkg::mul_lo32(d1_w, t2);
      s1_m2_r <= esc_pkg::mul_lo32(d2_w, d2_w);
      s2_v1_r <= $signed(s1_m1_r) >>> 11;
      s2_m3_r <= esc_pkg::mul_lo32($signed(s1_m2_r) >>> 12, t3);
      s3_tf_r <= s2_v1_r + m3s_w;
      tc_r[4] <= $signed(tf5_w + esc_pkg::T_RND) >>> 8;
      tf_r[4] <= s3_tf_r;
      for (int k = 5; k <= 13; k++) begin
        tc_r[k] <= tc_r[k-1];
        tf_r[k] <= tf_r[k-1];
      end
      s4_w1_r <= $signed({s3_tf_r[31], s3_tf_r} - esc_pkg::T_FINE_OFS);
      s4_hx_r <= s3_tf_r - esc_pkg::H_FINE_OFS;
      // pressure numerator and divisor
      s5_sq_r  <= sq_w[63:0];
      s5_a5_r  <= a5_w;
      s5_a2_r  <= a2_w;
      s6_p6l_r <= p6l_w;
      s6_p6h_r <= esc_pkg::mul_lo32(s5_sq_r[63:32], {{16{p6[15]}}, p6});
      s6_p3l_r <= p3l_w;
      s6_p3h_r <= esc_pkg::mul_lo32(s5_sq_r[63:32], {{16{p3[15]}}, p3});
      s6_a5_r  <= s5_a5_r;
      s6_a2_r  <= s5_a2_r;
      s7_w2_r  <= w2_w;
      s7_t3v_r <= t3v_w;
      s7_a2_r  <= s6_a2_r;
      s8_y_r   <= y_w;
      s8_nd_r  <= nd_w;
      s9_yl_r  <= yl_w;
      s9_yh_r  <= esc_pkg::mul_lo32(s8_y_r[63:32], {16'b0, p1});
      s9_nl_r  <= nl_w;
      s9_nh_r  <= esc_pkg::mul_lo32(s8_nd_r[63:32], esc_pkg::P_SCALE);
      num_r[10] <= num_w;
      den_r[10] <= z_w[63:33];
      for (int k = 11; k <= 13; k++) begin
        num_r[k] <= num_r[k-1];
        den_r[k] <= den_r[k-1];
      end
      // humidity
      s5_ma_r  <= esc_pkg::mul_lo32(h5, s4_hx_r);
      s5_mb_r  <= esc_pkg::mul_lo32(s4_hx_r, h6);
      s5_mc_r  <= esc_pkg::mul_lo32(s4_hx_r, h3);
      ha_r[6]  <= $signed({2'b0, ah_r[5], 14'b0} - {h4[11:0], 20'b0} - s5_ma_r
                          + esc_pkg::H_A_RND) >>> 15;
      for (int k = 7; k <= 10; k++) ha_r[k] <= ha_r[k-1];
      s6_hb_r  <= $signed(s5_mb_r) >>> 10;
      s6_hc_r  <= hc_w + esc_pkg::H_C_OFS;
      s7_md_r  <= esc_pkg::mul_lo32(s6_hb_r, s6_hc_r);
      s8_d_r   <= mds_w + esc_pkg::H_D_OFS;
      s9_me_r  <= esc_pkg::mul_lo32(s8_d_r, h2);
      s10_e_r  <= mes_w;
      xm_r[11] <= esc_pkg::mul_lo32(ha_r[10], s10_e_r);
      xm_r[12] <= xm_r[11];
      xm_r[13] <= xm_r[12];
      s12_mf_r <= esc_pkg::mul_lo32(xs_w, xs_w);
      s13_mg_r <= esc_pkg::mul_lo32(mfs_w, h1);
      // divider entry
      s14_an_r       <= an_w;
      s14_ad_r       <= ad_w;
      s14_side_r.tc  <= tc_r[13];
      s14_side_r.tf  <= tf_r[13];
      s14_side_r.hum <= xc_w[28:12];
      s14_side_r.neg <= nn_w ^ dn_w;
      s14_side_r.dz  <= (den_r[13] == 31'd0);
    end
  end

  logic           dv;
  logic [63:0]    dq;
  esc_pkg::side_t dside;

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv_r[14]),
    .in_num    (s14_an_r),
    .in_den    (s14_ad_r),
    .in_side   (s14_side_r),
    .out_valid (dv),
    .out_quo   (dq),
    .out_side  (dside)
  );

  // back end: quadratic and linear pressure corrections
  logic [5:1] bv_r;
  esc_pkg::side_t bs_r [1:5];
  logic [63:0] bp_r [1:5];
  logic [63:0] b2_mll_r, b3_sq2_r;
  logic [31:0] b2_mlh_r, b2_p8h_r, b4_p9h_r;
  logic signed [48:0] b2_p8l_r, b4_p9l_r;
  logic [39:0] b3_w2c_r, b4_w2c_r, b5_w2c_r, b5_w1c_r;

  logic [63:0] ps_w, mll_w, sq2_w, w2b_w, w2c_w, w1sum_w, w1c_w;
  logic signed [48:0] p8l_w, p9l_w;
  logic [39:0] s40_w;
  logic [31:0] press_w;

  assign ps_w    = $signed(bp_r[1]) >>> 13;
  assign mll_w   = 64'(ps_w[31:0]) * 64'(ps_w[31:0]);
  assign p8l_w   = $signed({1'b0, bp_r[1][31:0]}) * p8;
  assign sq2_w   = b2_mll_r + {b2_mlh_r[30:0], 33'b0};
  assign w2b_w   = {{15{b2_p8l_r[48]}}, b2_p8l_r} + {b2_p8h_r, 32'b0};
  assign w2c_w   = $signed(w2b_w) >>> 19;
  assign p9l_w   = $signed({1'b0, b3_sq2_r[31:0]}) * p9;
  assign w1sum_w = {{15{b4_p9l_r[48]}}, b4_p9l_r} + {b4_p9h_r, 32'b0};
  assign w1c_w   = $signed(w1sum_w) >>> 25;
  assign s40_w   = bp_r[5][39:0] + b5_w1c_r + b5_w2c_r;
  assign press_w = s40_w[39:8] + {{12{p7[15]}}, p7, 4'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[4:1], dv};
      out_valid_r <= bv_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bp_r[1] <= dside.neg ? (64'd0 - dq) : dq;
      bs_r[1] <= dside;
      for (int k = 2; k <= 5; k++) begin
        bp_r[k] <= bp_r[k-1];
        bs_r[k] <= bs_r[k-1];
      end
      b2_mll_r <= mll_w;
      b2_mlh_r <= esc_pkg::mul_lo32(ps_w[31:0], ps_w[63:32]);
      b2_p8l_r <= p8l_w;
      b2_p8h_r <= esc_pkg::mul_lo32(bp_r[1][63:32], {{16{p8[15]}}, p8});
      b3_sq2_r <= sq2_w;
      b3_w2c_r <= w2c_w[39:0];
      b4_p9l_r <= p9l_w;
      b4_p9h_r <= esc_pkg::mul_lo32(b3_sq2_r[63:32], {{16{p9[15]}}, p9});
      b4_w2c_r <= b3_w2c_r;
      b5_w1c_r <= w1c_w[39:0];
      b5_w2c_r <= b4_w2c_r;
      out_temperature_centi <= bs_r[5].tc;
      out_fine_temperature  <= bs_r[5].tf;
      out_humidity_q22_10   <= bs_r[5].hum;
      out_pressure_valid    <= !bs_r[5].dz;
      out_pressure_q24_8    <= bs_r[5].dz ? 32'd0 : press_w;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/esc_chk.sv =====
`include "assert_macros.svh"

module esc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [19:0] in_adc_temperature,
  input logic [19:0] in_adc_pressure,
  input logic [15:0] in_adc_humidity,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [31:0] out_temperature_centi,
  input logic signed [31:0] out_fine_temperature,
  input logic [31:0] out_pressure_q24_8,
  input logic        out_pressure_valid,
  input logic [16:0] out_humidity_q22_10,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [47:0] cfg_wdata
);

  `ESC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ESC_ASSERT(a_in_stall, !in_ready |-> out_valid && !out_ready, "request refused without stall")
  `ESC_ASSERT(a_press_zero, out_valid && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0, "invalid pressure not zero")
  `ESC_ASSERT(a_hum_range, out_valid |-> out_humidity_q22_10 <= 17'd102400, "humidity above full scale")
  `ESC_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind env_sensor_compensation_top esc_chk u_esc_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [19:0] in_adc_temperature;
  logic [19:0] in_adc_pressure;
  logic [15:0] in_adc_humidity;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_temperature_centi;
  logic signed [31:0] out_fine_temperature;
  logic [31:0] out_pressure_q24_8;
  logic        out_pressure_valid;
  logic [16:0] out_humidity_q22_10;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_wdata;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [31:0] press;
    logic        pvalid;
    logic [16:0] hum;
  } comp_res_t;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned PIPE_DRAIN  = 120;

  comp_res_t   pending_q[$];
  logic [47:0] cal_regs[6];
  int unsigned err_count;
  int unsigned sent_count;
  int unsigned got_count;
  int unsigned invalid_press_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  event        hold_go;

  env_sensor_compensation_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensation of one reading set against the current calibration copy
  function automatic comp_res_t compensate(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
    comp_res_t r;
    logic [31:0] t1, t2, t3, d1, v1, d2, v2, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, ps, an, ad, q;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, c, d, e, xs;
    t1 = {16'd0, cal_regs[0][15:0]};
    t2 = {{16{cal_regs[0][31]}}, cal_regs[0][31:16]};
    t3 = {{16{cal_regs[0][47]}}, cal_regs[0][47:32]};
    d1 = {12'd0, at} / 8 - (t1 << 1);
    v1 = asr32(d1 * t2, 11);
    d2 = {12'd0, at} / 16 - t1;
    v2 = asr32(asr32(d2 * d2, 12) * t3, 14);
    tf = v1 + v2;
    r.tf = tf;
    r.tc = asr32(tf * 32'd5 + 32'd128, 8);

    p1 = {48'd0, cal_regs[1][15:0]};
    p2 = sx16(cal_regs[1][31:16]);
    p3 = sx16(cal_regs[1][47:32]);
    p4 = sx16(cal_regs[2][15:0]);
    p5 = sx16(cal_regs[2][31:16]);
    p6 = sx16(cal_regs[2][47:32]);
    p7 = sx16(cal_regs[3][15:0]);
    p8 = sx16(cal_regs[3][31:16]);
    p9 = sx16(cal_regs[3][47:32]);
    w1 = {{32{tf[31]}}, tf} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
    r.press = '0;
    r.pvalid = 1'b0;
    if (w1 != 0) begin
      p = 64'd1048576 - {44'd0, ap};
      p = ((p << 31) - w2) * 64'd3125;
      an = p[63] ? -p : p;
      ad = w1[63] ? -w1 : w1;
      q = an / ad;
      p = (p[63] != w1[63]) ? -q : q;
      ps = asr64(p, 13);
      w1 = asr64(p9 * ps * ps, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      r.press = p[31:0];
      r.pvalid = 1'b1;
    end

    h1 = {24'd0, cal_regs[4][7:0]};
    h2 = {{16{cal_regs[4][23]}}, cal_regs[4][23:8]};
    h3 = {24'd0, cal_regs[4][31:24]};
    h4 = {{20{cal_regs[5][11]}}, cal_regs[5][11:0]};
    h5 = {{20{cal_regs[5][23]}}, cal_regs[5][23:12]};
    h6 = {{24{cal_regs[5][31]}}, cal_regs[5][31:24]};
    x = tf - 32'd76800;
    a = asr32(({16'd0, ah} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    b = asr32(x * h6, 10);
    c = asr32(x * h3, 11) + 32'd32768;
    d = asr32(b * c, 10) + 32'd2097152;
    e = asr32(d * h2 + 32'd8192, 14);
    x = a * e;
    xs = asr32(x, 15);
    x = x - asr32(asr32(xs * xs, 7) * h1, 4);
    if (x[31]) x = 0;
    else if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:12];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, got_count);
    err_count++;
  endtask

  task automatic write_cal(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx <= esc_pkg::REG_CAL_HUM_B)
      cal_regs[idx] = (idx >= esc_pkg::REG_CAL_HUM_A) ? {16'd0, val[31:0]} : val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_reading(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_adc_temperature = at;
    in_adc_pressure = ap;
    in_adc_humidity = ah;
    pending_q.push_back(compensate(at, ap, ah));
    sent_count++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // plausible factory-style calibration
  task automatic load_typical_cal();
    write_cal(esc_pkg::REG_CAL_TEMP, {16'd50, 16'd26435, 16'd27504});
    write_cal(esc_pkg::REG_CAL_PRESS_A, {16'd3024, -16'sd10685, 16'd36477});
    write_cal(esc_pkg::REG_CAL_PRESS_B, {-16'sd7, 16'd140, 16'd2855});
    write_cal(esc_pkg::REG_CAL_PRESS_C, {16'd6000, -16'sd14600, 16'd15500});
    write_cal(esc_pkg::REG_CAL_HUM_A, {16'd0, 8'd0, 16'd361, 8'd75});
    write_cal(esc_pkg::REG_CAL_HUM_B, {16'd0, 8'd30, 12'd50, 12'd321});
  endtask

  task automatic load_random_cal();
    for (int i = 0; i <= esc_pkg::REG_CAL_HUM_B; i++)
      write_cal(i[2:0], 48'({$urandom, $urandom}));
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_reading(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)),
                   16'($urandom_range(16'hFFFF)));
  endtask

  task automatic test_reset_cal();
    // all coefficients zero: divisor zero, so pressure flagged invalid
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_directed();
    load_typical_cal();
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_reading(20'd400000, 20'd300000, 16'd65535);
    send_reading(20'd600000, 20'd500000, 16'd0);
    wait_drained();
    // extreme coefficients
    write_cal(esc_pkg::REG_CAL_TEMP, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::REG_CAL_PRESS_A, 48'h7FFF_7FFF_FFFF);
    write_cal(esc_pkg::REG_CAL_PRESS_B, 48'h8000_8000_8000);
    write_cal(esc_pkg::REG_CAL_PRESS_C, 48'h7FFF_7FFF_7FFF);
    write_cal(esc_pkg::REG_CAL_HUM_A, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::REG_CAL_HUM_B, 48'h0000_8080_0800);
    write_cal(3'd7, 48'h1234_5678_9ABC);  // unmapped index, ignored
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h80000, 20'h80000, 16'h8000);
    wait_drained();
    write_cal(esc_pkg::REG_CAL_TEMP, 48'h8000_8000_0000);
    write_cal(esc_pkg::REG_CAL_PRESS_A, 48'h8000_8000_0001);
    write_cal(esc_pkg::REG_CAL_HUM_A, 48'h0000_7FFF_FF00);
    write_cal(esc_pkg::REG_CAL_HUM_B, 48'h0000_7F7F_F7FF);
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h12345, 20'h6789A, 16'hBCDE);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    int unsigned mix[4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{26, 26}};
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = mix[ph % 4][0];
      recv_stall_pct = mix[ph % 4][1];
      if (ph % 2 == 0) load_typical_cal();
      else load_random_cal();
      run_random(210);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    load_random_cal();
    -> hold_go;
    run_random(150);
    wait_drained();
  endtask

  task automatic test_typical_spread();
    // random tweaks of a believable calibration keep pressure valid most of the time
    load_typical_cal();
    write_cal(esc_pkg::REG_CAL_PRESS_A,
              {16'($urandom_range(65535)), 16'($urandom), 16'($urandom_range(65535, 20000))});
    recv_stall_pct = 10;
    run_random(140);
    recv_stall_pct = 0;
    wait_drained();
  endtask

  // receiver: random stalls, plus one long hold-off while the pipe fills
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_go);
      hold_off = 1'b1;
      repeat (400) @(negedge clk);
      hold_off = 1'b0;
    end
  end

  always @(posedge clk) begin
    comp_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", out_fine_temperature, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_temperature_centi !== want.tc)
          report_mismatch("temperature_centi", out_temperature_centi, want.tc);
        if (out_fine_temperature !== want.tf)
          report_mismatch("fine_temperature", out_fine_temperature, want.tf);
        if (out_pressure_q24_8 !== want.press)
          report_mismatch("pressure_q24_8", out_pressure_q24_8, want.press);
        if (out_pressure_valid !== want.pvalid)
          report_mismatch("pressure_valid", 32'(out_pressure_valid), 32'(want.pvalid));
        if (out_humidity_q22_10 !== want.hum)
          report_mismatch("humidity_q22_10", 32'(out_humidity_q22_10), 32'(want.hum));
        if (!want.pvalid) invalid_press_count++;
      end
      got_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycle_count, pending_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_temperature = '0;
    in_adc_pressure = '0;
    in_adc_humidity = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    invalid_press_count = 0;
    cycle_count = 0;
    for (int i = 0; i < 6; i++) cal_regs[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_cal();
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_typical_spread();

    $display("%0d requests sent, %0d results checked, %0d with pressure flagged invalid",
             sent_count, got_count, invalid_press_count);
    $display("covered reset and extreme calibration, random calibration, stalls, long hold-off");
    if (err_count == 0 && pending_q.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_div.sv
hdl/env_sensor_compensation_top.sv
hdl/esc_chk.sv
dv/testbench.sv
